FILE: design/integer_atan2_degrees_assert.svh
// ----------------------------------------------------------------------------
// integer_atan2_degrees assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef INTEGER_ATAN2_DEGREES_ASSERT_SVH
`define INTEGER_ATAN2_DEGREES_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IA2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define IA2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ia2d_pkg.sv
// ----------------------------------------------------------------------------
// ia2d_pkg
// widths, constants, side-band type and arctangent table for the atan2 block
// ----------------------------------------------------------------------------
`default_nettype none

package ia2d_pkg;

  localparam int COORD_W = 16;
  localparam int MAG_W   = COORD_W + 1;
  localparam int REM_W   = MAG_W + 1;
  localparam int Q_W     = 7;
  localparam int TAB_W   = 6;
  localparam int ANGLE_W = 9;
  localparam int TAB_N   = 65;

  localparam logic [Q_W-1:0]   IDX_MAX      = Q_W'(64);
  localparam logic [7:0]       DEG_RIGHT    = 8'd90;
  localparam logic [7:0]       DEG_STRAIGHT = 8'd180;
  localparam logic [TAB_W-1:0] DEG_HALF     = TAB_W'(45);

  typedef struct packed {
    logic zero;
    logic swap;
    logic x_neg;
    logic y_neg;
  } side_t;

  localparam logic [TAB_W-1:0] OCT_DEG_ROM [TAB_N] = '{
    6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd4,  6'd5,  6'd6,
    6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd11, 6'd12, 6'd13,
    6'd14, 6'd15, 6'd16, 6'd17, 6'd17, 6'd18, 6'd19, 6'd20,
    6'd21, 6'd21, 6'd22, 6'd23, 6'd24, 6'd24, 6'd25, 6'd26,
    6'd27, 6'd27, 6'd28, 6'd29, 6'd29, 6'd30, 6'd31, 6'd31,
    6'd32, 6'd33, 6'd33, 6'd34, 6'd35, 6'd35, 6'd36, 6'd36,
    6'd37, 6'd37, 6'd38, 6'd39, 6'd39, 6'd40, 6'd40, 6'd41,
    6'd41, 6'd42, 6'd42, 6'd43, 6'd43, 6'd44, 6'd44, 6'd45,
    6'd45
  };

  function automatic logic [TAB_W-1:0] atan_deg(input logic [Q_W-1:0] idx);
    logic [TAB_W-1:0] val;
    if (idx > IDX_MAX) begin
      val = DEG_HALF;
    end else begin
      val = OCT_DEG_ROM[idx];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: design/ia2d_front.sv
// ----------------------------------------------------------------------------
// ia2d_front
// magnitudes, octant swap and sign capture, one register stage
// ----------------------------------------------------------------------------
`default_nettype none

module ia2d_front
  import ia2d_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     valid_i,
  output logic                          ready_o,
  input  wire logic signed [COORD_W-1:0] y_i,
  input  wire logic signed [COORD_W-1:0] x_i,
  output logic                          valid_o,
  input  wire logic                     ready_i,
  output logic [REM_W-1:0]              rem_o,
  output logic [MAG_W-1:0]              large_o,
  output side_t                         side_o
);

  logic [MAG_W-1:0] ay;
  logic [MAG_W-1:0] ax;
  logic             swap;
  side_t            side_next;

  always_comb begin
    ay = y_i[COORD_W-1] ? (MAG_W'(1) << COORD_W) - {1'b0, y_i} : {1'b0, y_i};
    ax = x_i[COORD_W-1] ? (MAG_W'(1) << COORD_W) - {1'b0, x_i} : {1'b0, x_i};
    swap = ay > ax;
    side_next.zero  = (ay == '0) && (ax == '0);
    side_next.swap  = swap;
    side_next.x_neg = x_i[COORD_W-1];
    side_next.y_neg = y_i[COORD_W-1];
  end

  assign ready_o = !valid_o || ready_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      rem_o   <= {1'b0, (swap ? ax : ay)};
      large_o <= swap ? ay : ax;
      side_o  <= side_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/ia2d_div_stage.sv
// ----------------------------------------------------------------------------
// ia2d_div_stage
// restoring division stage, STEPS quotient bits per register stage
// ----------------------------------------------------------------------------
`default_nettype none

module ia2d_div_stage
  import ia2d_pkg::*;
#(
  parameter bit FIRST = 1'b0,
  parameter int STEPS = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [REM_W-1:0] rem_i,
  input  wire logic [MAG_W-1:0] large_i,
  input  wire logic [Q_W-1:0]   quot_i,
  input  wire side_t            side_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [REM_W-1:0]      rem_o,
  output logic [MAG_W-1:0]      large_o,
  output logic [Q_W-1:0]        quot_o,
  output side_t                 side_o
);

  logic [REM_W-1:0] rem_next;
  logic [Q_W-1:0]   quot_next;

  // remainder stays below the divisor, so the shift never overflows
  always_comb begin
    rem_next  = rem_i;
    quot_next = quot_i;
    for (int i = 0; i < STEPS; i++) begin
      if (!(FIRST && (i == 0))) begin
        rem_next = {rem_next[REM_W-2:0], 1'b0};
      end
      if (rem_next >= {1'b0, large_i}) begin
        rem_next  = rem_next - {1'b0, large_i};
        quot_next = {quot_next[Q_W-2:0], 1'b1};
      end else begin
        quot_next = {quot_next[Q_W-2:0], 1'b0};
      end
    end
  end

  assign ready_o = !valid_o || ready_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      rem_o   <= rem_next;
      large_o <= large_i;
      quot_o  <= quot_next;
      side_o  <= side_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/ia2d_back.sv
// ----------------------------------------------------------------------------
// ia2d_back
// table lookup, octant and quadrant fold, output register
// ----------------------------------------------------------------------------
`default_nettype none

module ia2d_back
  import ia2d_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire logic [Q_W-1:0] quot_i,
  input  wire side_t          side_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output logic [ANGLE_W-1:0]  angle_o
);

  logic [7:0]         tab_val;
  logic [7:0]         oct_val;
  logic [7:0]         half_val;
  logic [ANGLE_W-1:0] angle_next;

  always_comb begin
    tab_val  = {2'b00, atan_deg(quot_i)};
    oct_val  = side_i.swap ? DEG_RIGHT - tab_val : tab_val;
    half_val = side_i.x_neg ? DEG_STRAIGHT - oct_val : oct_val;
    if (side_i.zero) begin
      angle_next = '0;
    end else if (side_i.y_neg) begin
      angle_next = ANGLE_W'(0) - {1'b0, half_val};
    end else begin
      angle_next = {1'b0, half_val};
    end
  end

  assign ready_o = !valid_o || ready_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      angle_o <= angle_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/integer_atan2_degrees.sv
// ----------------------------------------------------------------------------
// integer_atan2_degrees
// four-quadrant arctangent of a 16-bit vector in whole degrees
//
//   channel  signals                          direction
//   in       in_valid in_ready y_coord x_coord  sink
//   out      out_valid out_ready angle_deg     source
//
// one item per cycle sustained while out_ready is held high
// five register stages: front, three divider stages, back
// the divider yields seven quotient bits, three then two then two per stage
// every stage has its own valid bit; a stall fills bubbles before holding
// synchronous reset clears all valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module integer_atan2_degrees
  import ia2d_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] y_coord,
  input  wire logic signed [COORD_W-1:0] x_coord,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [ANGLE_W-1:0]      angle_deg
);

  logic             v0, v1, v2, v3;
  logic             r1, r2, r3, r4;
  logic [REM_W-1:0] rem0, rem1, rem2, rem3;
  logic [MAG_W-1:0] large0, large1, large2, large3;
  logic [Q_W-1:0]   quot1, quot2, quot3;
  side_t            side0, side1, side2, side3;
  logic [ANGLE_W-1:0] angle;

  ia2d_front u_front (
    .clk     (clk),
    .rst     (rst),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .y_i     (y_coord),
    .x_i     (x_coord),
    .valid_o (v0),
    .ready_i (r1),
    .rem_o   (rem0),
    .large_o (large0),
    .side_o  (side0)
  );

  ia2d_div_stage #(.FIRST(1'b1), .STEPS(3)) u_div1 (
    .clk     (clk),
    .rst     (rst),
    .valid_i (v0),
    .ready_o (r1),
    .rem_i   (rem0),
    .large_i (large0),
    .quot_i  ('0),
    .side_i  (side0),
    .valid_o (v1),
    .ready_i (r2),
    .rem_o   (rem1),
    .large_o (large1),
    .quot_o  (quot1),
    .side_o  (side1)
  );

  ia2d_div_stage #(.FIRST(1'b0), .STEPS(2)) u_div2 (
    .clk     (clk),
    .rst     (rst),
    .valid_i (v1),
    .ready_o (r2),
    .rem_i   (rem1),
    .large_i (large1),
    .quot_i  (quot1),
    .side_i  (side1),
    .valid_o (v2),
    .ready_i (r3),
    .rem_o   (rem2),
    .large_o (large2),
    .quot_o  (quot2),
    .side_o  (side2)
  );

  ia2d_div_stage #(.FIRST(1'b0), .STEPS(2)) u_div3 (
    .clk     (clk),
    .rst     (rst),
    .valid_i (v2),
    .ready_o (r3),
    .rem_i   (rem2),
    .large_i (large2),
    .quot_i  (quot2),
    .side_i  (side2),
    .valid_o (v3),
    .ready_i (r4),
    .rem_o   (rem3),
    .large_o (large3),
    .quot_o  (quot3),
    .side_o  (side3)
  );

  ia2d_back u_back (
    .clk     (clk),
    .rst     (rst),
    .valid_i (v3),
    .ready_o (r4),
    .quot_i  (quot3),
    .side_i  (side3),
    .valid_o (out_valid),
    .ready_i (out_ready),
    .angle_o (angle)
  );

  assign angle_deg = $signed(angle);

endmodule

`default_nettype wire

FILE: design/ia2d_checker.sv
// ----------------------------------------------------------------------------
// ia2d_checker
// port-level checks for integer_atan2_degrees, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_atan2_degrees_assert.svh"

module ia2d_checker
  import ia2d_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic signed [COORD_W-1:0] y_coord,
  input wire logic signed [COORD_W-1:0] x_coord,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [ANGLE_W-1:0] angle_deg
);

  localparam logic signed [ANGLE_W-1:0] ANGLE_LO = ANGLE_W'(-180);
  localparam logic signed [ANGLE_W-1:0] ANGLE_HI = ANGLE_W'(180);

  logic                   in_wait;
  logic                   out_wait;
  logic                   angle_ok;
  logic [2*COORD_W-1:0]   in_payload;

  assign in_wait    = in_valid && !in_ready;
  assign out_wait   = out_valid && !out_ready;
  assign angle_ok   = (angle_deg >= ANGLE_LO) && (angle_deg <= ANGLE_HI);
  assign in_payload = {y_coord, x_coord};

  `IA2D_ASSERT_NEXT(a_in_hold, in_wait, in_valid && $stable(in_payload), "input item changed")
  `IA2D_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(angle_deg), "held item changed")
  `IA2D_ASSERT_NOW(a_angle_range, out_valid, angle_ok, "angle out of range")
  `IA2D_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
  `IA2D_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "output valid right after reset")

endmodule

bind integer_atan2_degrees ia2d_checker u_ia2d_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .y_coord   (y_coord),
  .x_coord   (x_coord),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .angle_deg (angle_deg)
);

`default_nettype wire
